@@ src/dll_pkg.sv @@
// ----------------------------------------------------------------------------
// dll_pkg: shared types and constants of the data line lexer
// Token kinds, the token record and the per-byte scan bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package dll_pkg;

    // Longest source the position counter is sized for; offsets saturate below it.
    localparam int unsigned MAX_SOURCE_LEN = 65536;
    localparam logic [15:0] POS_LIMIT =
        (MAX_SOURCE_LEN - 1 < 65535) ? 16'(MAX_SOURCE_LEN - 1) : 16'hFFFF;

    typedef enum logic [2:0] {
        K_IDENT   = 3'd0,
        K_INT     = 3'd1,
        K_FLOAT   = 3'd2,
        K_NEWLINE = 3'd3,
        K_STAR    = 3'd4,
        K_END     = 3'd5,
        K_BAD     = 3'd6,
        K_DOUBLE  = 3'd7
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } t_tok;

    // Results of one byte: count (0..3) and the tokens in order.
    typedef struct packed {
        logic [1:0]     cnt;
        t_tok [2:0]     tok;
    } t_scan_out;

endpackage

`default_nettype wire

@@ src/dll_scan.sv @@
// ----------------------------------------------------------------------------
// dll_scan: scanner state and per-byte token logic
// Holds mode, position, token start and point flag; works out up to three
// tokens for the byte on the input and advances the state when it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dll_scan
    import dll_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_SOURCE_LEN
)
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_source_byte,
    input  wire logic       i_is_final,
    output t_scan_out       o_step
);

    typedef enum logic [4:0] {
        M_IDLE   = 5'b00001,
        M_IDENT  = 5'b00010,
        M_NUMBER = 5'b00100,
        M_SIGN   = 5'b01000,
        M_HALT   = 5'b10000
    } t_mode;

    typedef struct packed {
        logic vld;
        t_tok tok;
    } t_cand;

    // Highest offset the position counter reaches before it saturates.
    localparam logic [15:0] POS_MAX =
        (MAX_LEN - 1 < 65535) ? 16'(MAX_LEN - 1) : 16'hFFFF;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    function automatic t_tok mk_tok(input t_kind k, input logic [15:0] s,
                                    input logic [15:0] l);
        t_tok t;
        t.kind  = k;
        t.start = s;
        t.len   = l;
        t.last  = 1'b0;
        return t;
    endfunction

    t_mode       r_mode, n_mode;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_ts, n_ts;
    logic        r_sp, n_sp;

    t_cand [3:0] cand;
    t_tok  [2:0] res;
    logic  [1:0] cnt;

    always_comb begin
        logic [7:0]  c;
        logic        do_begin;
        logic [16:0] endp;
        logic [15:0] len_now;
        logic [16:0] len_end;

        c        = i_source_byte;
        do_begin = 1'b0;
        n_mode   = r_mode;
        n_ts     = r_ts;
        n_sp     = r_sp;
        n_pos    = r_pos;
        cand     = '0;
        endp     = {1'b0, r_pos} + 17'd1;
        len_now  = r_pos - r_ts;

        if (r_mode != M_HALT) begin
            // Continue or close the pending token.
            unique case (r_mode)
                M_IDENT: begin
                    if (!(is_letter(c) || is_digit(c) || c == CH_MINUS)) begin
                        cand[0].vld = 1'b1;
                        cand[0].tok = mk_tok(K_IDENT, r_ts, len_now);
                        do_begin    = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (c == CH_POINT) begin
                        if (r_sp) begin
                            cand[0].vld = 1'b1;
                            cand[0].tok = mk_tok(K_DOUBLE, r_pos, 16'd0);
                            n_mode      = M_HALT;
                        end else begin
                            n_sp = 1'b1;
                        end
                    end else if (!is_digit(c)) begin
                        cand[0].vld = 1'b1;
                        cand[0].tok = mk_tok(r_sp ? K_FLOAT : K_INT, r_ts, len_now);
                        do_begin    = 1'b1;
                    end
                end
                M_SIGN: begin
                    if (is_digit(c)) begin
                        n_mode = M_NUMBER;
                    end else begin
                        cand[0].vld = 1'b1;
                        cand[0].tok = mk_tok(K_BAD, r_ts, 16'd0);
                        n_mode      = M_HALT;
                    end
                end
                default: begin
                    do_begin = 1'b1;
                end
            endcase

            // Scan the byte as the start of something new.
            if (do_begin) begin
                n_mode = M_IDLE;
                if (is_blank(c)) begin
                    n_mode = M_IDLE;
                end else if (c == CH_NL) begin
                    cand[1].vld = 1'b1;
                    cand[1].tok = mk_tok(K_NEWLINE, r_pos, 16'd1);
                end else if (c == CH_STAR) begin
                    cand[1].vld = 1'b1;
                    cand[1].tok = mk_tok(K_STAR, r_pos, 16'd1);
                end else if (is_letter(c)) begin
                    n_mode = M_IDENT;
                    n_ts   = r_pos;
                end else if (is_digit(c)) begin
                    n_mode = M_NUMBER;
                    n_ts   = r_pos;
                    n_sp   = 1'b0;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    n_mode = M_SIGN;
                    n_ts   = r_pos;
                    n_sp   = 1'b0;
                end else begin
                    cand[1].vld = 1'b1;
                    cand[1].tok = mk_tok(K_BAD, r_pos, 16'd0);
                    n_mode      = M_HALT;
                end
            end

            // Final byte: flush the open token and add END, or BAD for a sign.
            len_end = endp - {1'b0, n_ts};
            if (i_is_final && n_mode != M_HALT) begin
                if (n_mode == M_IDENT) begin
                    cand[2].vld = 1'b1;
                    cand[2].tok = mk_tok(K_IDENT, n_ts, sat16(len_end));
                end else if (n_mode == M_NUMBER) begin
                    cand[2].vld = 1'b1;
                    cand[2].tok = mk_tok(n_sp ? K_FLOAT : K_INT, n_ts, sat16(len_end));
                end
                if (n_mode == M_SIGN) begin
                    cand[2].vld = 1'b1;
                    cand[2].tok = mk_tok(K_BAD, n_ts, 16'd0);
                end else begin
                    cand[3].vld = 1'b1;
                    cand[3].tok = mk_tok(K_END, sat16(endp), 16'd0);
                end
                n_mode = M_HALT;
            end

            n_pos = (r_pos >= POS_MAX) ? POS_MAX : r_pos + 16'd1;
        end else begin
            len_end = '0;
        end
    end

    // Pack the valid candidates in order, at most three.
    always_comb begin
        res = '0;
        cnt = 2'd0;
        for (int k = 0; k < 4; k++) begin
            if (cand[k].vld && cnt != 2'd3) begin
                res[cnt] = cand[k].tok;
                cnt      = cnt + 2'd1;
            end
        end
        if (cnt != 2'd0) begin
            res[cnt - 2'd1].last = 1'b1;
        end
    end

    assign o_step.cnt = cnt;
    assign o_step.tok = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pos  <= '0;
            r_ts   <= '0;
            r_sp   <= 1'b0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_ts   <= n_ts;
            r_sp   <= n_sp;
        end
    end

endmodule

`default_nettype wire

@@ src/data_line_lexer_unit.sv @@
// Output: the tokens of a byte are registered into the queue when the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one token and output
//   is not stalled; a byte with two or three tokens holds input (four-slot queue).
// Output stall: input is taken while the queue holds at most one token.
// Reset: synchronous, active low; scanner returns to idle at offset zero, queue empties.
// ----------------------------------------------------------------------------
// data_line_lexer_unit: streaming lexer for one source text
// Takes one byte per transaction and reports identifiers, numbers, newline,
// star, END and errors as kind, start offset and length.
// ----------------------------------------------------------------------------
`default_nettype none

module data_line_lexer_unit
    import dll_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_SOURCE_LEN
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_source_byte,
    input  wire logic        i_is_final,
    // token channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_token_kind,
    output logic [15:0]      o_start_pos,
    output logic [15:0]      o_token_len,
    output logic             o_last_in_run
);

    localparam int QDEPTH = 4;

    t_scan_out   step;
    logic        take;
    logic        pop;
    logic [2:0]  npush;
    logic [2:0]  base;

    t_tok        r_q [QDEPTH];
    t_tok        n_q [QDEPTH];
    logic [2:0]  r_cnt, n_cnt;

    // Accept a byte only when the queue can absorb three tokens after it.
    assign o_in_ready = (r_cnt <= 3'd1);
    assign take       = i_in_valid && o_in_ready;

    dll_scan #(
        .MAX_LEN (MAX_LEN)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_source_byte (i_source_byte),
        .i_is_final    (i_is_final),
        .o_step        (step)
    );

    // Head of the queue drives the token channel.
    assign o_out_valid   = (r_cnt != 3'd0);
    assign pop           = o_out_valid && i_out_ready;
    assign o_token_kind  = r_q[0].kind;
    assign o_start_pos   = r_q[0].start;
    assign o_token_len   = r_q[0].len;
    assign o_last_in_run = r_q[0].last;

    assign npush = take ? {1'b0, step.cnt} : 3'd0;
    assign base  = r_cnt - {2'b00, pop};
    assign n_cnt = base + npush;

    // Shift out the head on pop, then append new tokens behind the survivors.
    always_comb begin
        logic [2:0] off;
        for (int i = 0; i < QDEPTH; i++) begin
            off = 3'(i) - base;
            if (3'(i) < base) begin
                n_q[i] = (pop && i < QDEPTH - 1) ? r_q[(i + 1) % QDEPTH] : r_q[i];
            end else if (off < npush) begin
                n_q[i] = step.tok[off[1:0]];
            end else begin
                n_q[i] = r_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ src/dll_checker.sv @@
// ----------------------------------------------------------------------------
// dll_checker: port-level checks of the data line lexer
// Watches both channels for handshake and token shape slips.
// ----------------------------------------------------------------------------
`default_nettype none

module dll_checker
    import dll_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        o_in_ready,
    input  wire logic [7:0]  i_source_byte,
    input  wire logic        i_is_final,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [2:0]  o_token_kind,
    input  wire logic [15:0] o_start_pos,
    input  wire logic [15:0] o_token_len,
    input  wire logic        o_last_in_run
);

    // Hold a stalled byte transaction.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_source_byte) && $stable(i_is_final))
        else $error("stalled byte dropped or changed");

    // Hold a stalled transaction.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("token dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_token_kind) && $stable(o_start_pos) &&
            $stable(o_token_len) && $stable(o_last_in_run))
        else $error("stalled token changed");

    // END and errors carry no length.
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_kind == K_END || o_token_kind == K_BAD ||
                        o_token_kind == K_DOUBLE) |-> o_token_len == 16'd0)
        else $error("END or error token with length");

    a_single_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_kind == K_NEWLINE || o_token_kind == K_STAR)
            |-> o_token_len == 16'd1)
        else $error("newline or star token not one byte");

endmodule

bind data_line_lexer_unit dll_checker u_dll_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_source_byte (i_source_byte),
    .i_is_final    (i_is_final),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_token_kind  (o_token_kind),
    .o_start_pos   (o_start_pos),
    .o_token_len   (o_token_len),
    .o_last_in_run (o_last_in_run)
);

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for data_line_lexer_unit
// Feeds one source text byte by byte (directed opening, random token streams,
// a longer blank, identifier or number stretch, then one closing case) and
// compares every token transaction against a bit-accurate scanner kept here.
// ----------------------------------------------------------------------------

module tb_top;
    import dll_pkg::*;

    // Characters the scanner reacts to
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    // Bytes in the long stretch, in the ignored tail, and per random half
    localparam int unsigned LONG_LEN  = 24;
    localparam int unsigned TAIL_LEN  = 20;
    localparam int unsigned RAND_HALF = 95;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_NUMBER,
        SCAN_SIGN,
        SCAN_HALT
    } t_scan_mode;

    typedef enum int {
        CLOSE_FINAL,
        CLOSE_SIGN_FINAL,
        CLOSE_SIGN_STRAY,
        CLOSE_DOUBLE_POINT,
        CLOSE_BAD_BYTE
    } t_close;

    typedef enum int {
        LONG_BLANKS,
        LONG_IDENT,
        LONG_NUMBER
    } t_long;

    typedef struct packed {
        logic       fin;
        logic [7:0] ch;
    } t_src_item;

    // ------------------------------------------------------------------
    // Token scoreboard: tracks scanner state, queues the tokens each byte
    // must produce and checks the token transactions in order.
    // ------------------------------------------------------------------
    class token_tracker;
        t_scan_mode  mode;
        int unsigned pos;
        int unsigned tok_start;
        bit          point_seen;
        t_tok        step_tokens[$];
        t_tok        due_tokens[$];
        int unsigned mismatch_cnt;
        int unsigned tokens_matched;

        function new();
            mode           = SCAN_IDLE;
            pos            = 0;
            tok_start      = 0;
            point_seen     = 1'b0;
            mismatch_cnt   = 0;
            tokens_matched = 0;
        endfunction

        static function bit is_letter(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        static function bit is_digit(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        static function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
        endfunction

        function void add(t_kind k, int unsigned s, int unsigned n);
            t_tok t;
            t.kind  = k;
            t.start = (s > 65535) ? 16'hFFFF : 16'(s);
            t.len   = (n > 65535) ? 16'hFFFF : 16'(n);
            t.last  = 1'b0;
            step_tokens = {step_tokens, t};
        endfunction

        function void halt_on(t_kind k, int unsigned p);
            add(k, p, 0);
            mode = SCAN_HALT;
        endfunction

        // Scan a byte as if nothing were pending
        function void start_fresh(logic [7:0] c, int unsigned p);
            mode = SCAN_IDLE;
            if (is_blank(c)) begin
                return;
            end
            if (c == CH_NEWLINE) begin
                add(K_NEWLINE, p, 1);
            end else if (c == CH_STAR) begin
                add(K_STAR, p, 1);
            end else if (is_letter(c)) begin
                mode      = SCAN_IDENT;
                tok_start = p;
            end else if (is_digit(c)) begin
                mode       = SCAN_NUMBER;
                tok_start  = p;
                point_seen = 1'b0;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
                mode       = SCAN_SIGN;
                tok_start  = p;
                point_seen = 1'b0;
            end else begin
                halt_on(K_BAD, p);
            end
        endfunction

        // Accepted byte: work out its tokens and queue them
        function void note_byte(logic [7:0] c, logic fin);
            int unsigned p;
            int unsigned stop;
            p = pos;
            if (mode == SCAN_HALT) begin
                return;
            end
            step_tokens.delete();
            case (mode)
                SCAN_IDENT: begin
                    if (!(is_letter(c) || is_digit(c) || c == CH_MINUS)) begin
                        add(K_IDENT, tok_start, p - tok_start);
                        start_fresh(c, p);
                    end
                end
                SCAN_NUMBER: begin
                    if (c == CH_POINT) begin
                        if (point_seen) halt_on(K_DOUBLE, p);
                        else point_seen = 1'b1;
                    end else if (!is_digit(c)) begin
                        add(point_seen ? K_FLOAT : K_INT, tok_start, p - tok_start);
                        start_fresh(c, p);
                    end
                end
                SCAN_SIGN: begin
                    if (is_digit(c)) mode = SCAN_NUMBER;
                    else halt_on(K_BAD, tok_start);
                end
                default: begin
                    start_fresh(c, p);
                end
            endcase

            // Final byte: flush what is open and add END, or BAD for a sign
            if (fin && mode != SCAN_HALT) begin
                stop = p + 1;
                case (mode)
                    SCAN_IDENT:  add(K_IDENT, tok_start, stop - tok_start);
                    SCAN_NUMBER: add(point_seen ? K_FLOAT : K_INT, tok_start, stop - tok_start);
                    SCAN_SIGN:   halt_on(K_BAD, tok_start);
                    default: ;
                endcase
                if (mode != SCAN_HALT) add(K_END, stop, 0);
                mode = SCAN_HALT;
            end

            pos = (p >= POS_LIMIT) ? POS_LIMIT : p + 1;
            if (step_tokens.size() != 0) begin
                step_tokens[step_tokens.size() - 1].last = 1'b1;
            end
            due_tokens = {due_tokens, step_tokens};
        endfunction

        function void check_token(logic [2:0] kind, logic [15:0] start, logic [15:0] len,
                                  logic last);
            t_tok e;
            if (due_tokens.size() == 0) begin
                $error("unexpected token: token_kind %0d start_pos %0d token_len %0d",
                       kind, start, len);
                mismatch_cnt++;
                return;
            end
            e = due_tokens.pop_front();
            tokens_matched++;
            if (kind !== e.kind) begin
                $error("token_kind: expected %0d, got %0d", e.kind, kind);
                mismatch_cnt++;
            end
            if (start !== e.start) begin
                $error("start_pos: expected %0d, got %0d", e.start, start);
                mismatch_cnt++;
            end
            if (len !== e.len) begin
                $error("token_len: expected %0d, got %0d", e.len, len);
                mismatch_cnt++;
            end
            if (last !== e.last) begin
                $error("last_in_run: expected %0d, got %0d", e.last, last);
                mismatch_cnt++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_byte   = 8'h00;
    logic        in_final  = 1'b0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [2:0]  tok_kind;
    logic [15:0] tok_start_pos;
    logic [15:0] tok_len;
    logic        tok_last;

    always #1 clk = ~clk;

    data_line_lexer_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_source_byte (in_byte),
        .i_is_final    (in_final),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_token_kind  (tok_kind),
        .o_start_pos   (tok_start_pos),
        .o_token_len   (tok_len),
        .o_last_in_run (tok_last)
    );

    token_tracker tracker;
    t_src_item    src_q[$];
    int unsigned  burst_left    = 0;
    int unsigned  bytes_taken   = 0;
    bit           prev_wordish  = 1'b0;
    int unsigned  rx_cycle      = 0;
    int unsigned  rx_hold_left  = 0;

    // ------------------------------------------------------------------
    // Receiver: own stall pattern, stall-free windows, and one long
    // hold-off early on so the result queue fills and input stalls.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end else if (rx_cycle == 200) begin
            // hold off for a long stretch while bytes keep coming
            rx_hold_left = 80;
            out_ready <= 1'b0;
        end else if (rx_cycle % 400 < 100) begin
            out_ready <= 1'b1;
        end else if (rx_cycle % 23 < 5) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 3) != 0);
        end
        rx_cycle++;
    end

    // Check every token transaction against the oldest pending token
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            tracker.check_token(tok_kind, tok_start_pos, tok_len, tok_last);
        end
    end

    // ------------------------------------------------------------------
    // Source text building
    // ------------------------------------------------------------------
    function void put(logic [7:0] c, logic fin = 1'b0);
        t_src_item it;
        it.ch  = c;
        it.fin = fin;
        src_q = {src_q, it};
    endfunction

    function void put_text(string s);
        foreach (s[i]) put(s[i]);
    endfunction

    function logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'($urandom_range(0, 25));
    endfunction

    function logic [7:0] rand_blank();
        case ($urandom_range(0, 4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            3:       return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function logic [7:0] rand_sign();
        return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
    endfunction

    // Letters, digits or dash: anything that keeps an identifier going
    function logic [7:0] rand_ident_tail();
        int unsigned r;
        r = $urandom_range(0, 62);
        if (r < 26) return CH_UPPER_A + 8'(r);
        if (r < 52) return CH_LOWER_A + 8'(r - 26);
        if (r < 62) return CH_ZERO + 8'(r - 52);
        return CH_MINUS;
    endfunction

    function void put_digits(int unsigned n);
        repeat (n) put(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // A byte no scanner state accepts when idle
    function logic [7:0] rand_bad_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (token_tracker::is_letter(c) || token_tracker::is_digit(c) ||
                   token_tracker::is_blank(c) || c == CH_NEWLINE || c == CH_STAR ||
                   c == CH_PLUS || c == CH_MINUS);
        return c;
    endfunction

    // Append one well-formed piece; separate a number from a preceding
    // word or number so the two never merge into an error.
    function void put_piece();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick >= 3 && pick <= 6 && prev_wordish) put(rand_blank());
        prev_wordish = 1'b0;
        case (pick)
            0, 1, 2: begin
                put(rand_letter());
                repeat ($urandom_range(0, 6)) put(rand_ident_tail());
                prev_wordish = 1'b1;
            end
            3, 4, 5, 6: begin
                if (pick >= 5) put(rand_sign());
                put_digits($urandom_range(1, 4));
                if (pick == 4 || pick == 6) begin
                    put(CH_POINT);
                    put_digits($urandom_range(0, 3));
                end
                prev_wordish = 1'b1;
            end
            7: put(CH_NEWLINE);
            8: put(CH_STAR);
            default: repeat ($urandom_range(1, 3)) put(rand_blank());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: drive the built text, in bursts with random gaps unless
    // steady; update the scoreboard on every accepted transaction.
    // ------------------------------------------------------------------
    task automatic send_text(input bit steady);
        t_src_item   it;
        int unsigned gap;
        while (src_q.size() != 0) begin
            it = src_q.pop_front();
            if (!steady && burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            if (burst_left != 0) burst_left--;
            in_valid <= 1'b1;
            in_byte  <= it.ch;
            in_final <= it.fin;
            do @(posedge clk); while (!in_ready);
            tracker.note_byte(it.ch, it.fin);
            bytes_taken++;
        end
    endtask

    // Drop valid and wait until every pending token is out, with a bound
    task automatic drain(input int unsigned bound);
        int unsigned waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.due_tokens.size() != 0 && waited < bound) begin
            @(posedge clk);
            waited++;
        end
    endtask

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_close      closing;
        t_long       stretch;
        int unsigned split;
        tracker = new();
        closing = t_close'($urandom_range(0, 4));
        stretch = t_long'($urandom_range(0, 2));

        // Hold reset, then release it for good
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: identifier with dash and extremes, signed float
        // with a bare point ended by a star, newline, signed int, every
        // blank, and a float ended by a letter that opens an identifier.
        put_text("Az-9");
        put(CH_TAB);
        put_text("+0.");
        put(CH_STAR);
        put(CH_NEWLINE);
        put_text("-7");
        put(CH_CR);
        put(CH_VT);
        put(CH_FF);
        put_text("9.5Zz");
        put(CH_SPACE);
        send_text(1'b0);

        // Random well-formed token stream, first half
        while (src_q.size() < RAND_HALF) put_piece();
        send_text(1'b0);

        // Pause until every token so far has come out
        drain(5000);

        // Second half, run with or without sender gaps, picked at random
        while (src_q.size() < RAND_HALF) put_piece();
        send_text(1'($urandom_range(0, 1)));

        // Long stretch: one extended blank run, identifier or number
        put(CH_SPACE);
        case (stretch)
            LONG_BLANKS: repeat (LONG_LEN) put(rand_blank());
            LONG_IDENT: begin
                put(rand_letter());
                repeat (LONG_LEN - 1) put(rand_ident_tail());
            end
            default: begin
                split = $urandom_range(1, LONG_LEN - 2);
                put_digits(split);
                put(CH_POINT);
                put_digits(LONG_LEN - 1 - split);
            end
        endcase
        send_text(1'b1);

        // Closing case: each one stops the scanner for the rest of the run
        case (closing)
            CLOSE_FINAL: begin
                if ($urandom_range(0, 1)) put_piece();
                if (src_q.size() == 0) put(rand_blank());
                src_q[src_q.size() - 1].fin = 1'b1;
            end
            CLOSE_SIGN_FINAL: begin
                put(CH_SPACE);
                put(rand_sign(), 1'b1);
            end
            CLOSE_SIGN_STRAY: begin
                put(CH_SPACE);
                put(rand_sign());
                case ($urandom_range(0, 5))
                    0:       put(rand_letter());
                    1:       put(CH_POINT);
                    2:       put(CH_STAR);
                    3:       put(CH_NEWLINE);
                    4:       put(rand_sign());
                    default: put(rand_blank());
                endcase
            end
            CLOSE_DOUBLE_POINT: begin
                put(CH_SPACE);
                put_digits($urandom_range(1, 3));
                put(CH_POINT);
                put_digits($urandom_range(0, 2));
                put(CH_POINT);
            end
            default: begin
                put(CH_SPACE);
                put(rand_bad_byte());
            end
        endcase
        // Anything after the stop must be ignored: any byte, any flag
        repeat (TAIL_LEN) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_text(1'b0);

        drain(5000);
        repeat (20) @(posedge clk);
        if (tracker.due_tokens.size() != 0) begin
            $error("%0d expected tokens never arrived", tracker.due_tokens.size());
            tracker.mismatch_cnt++;
        end

        $display("run covered %0d source bytes with a %s stretch, closed by %s",
                 bytes_taken, stretch.name(), closing.name());
        $display("%0d tokens compared, %0d mismatches",
                 tracker.tokens_matched, tracker.mismatch_cnt);
        if (tracker.mismatch_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ data_line_lexer_unit.f @@
src/dll_pkg.sv
src/dll_scan.sv
src/data_line_lexer_unit.sv
src/dll_checker.sv
sim/tb_top.sv
